/* hw/rtl/rmaa_pkg.sv */
`timescale 1ns / 1ps
package rmaa_pkg;
   localparam int FRACTION_BITS_DEF = 14;
   localparam int CORDIC_ITERATIONS_DEF = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam logic [33:0] PI_Q30 = 34'd3373259426;
   localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;

   localparam logic [1:0] KIND_GENERAL = 2'd0;
   localparam logic [1:0] KIND_ZERO = 2'd1;
   localparam logic [1:0] KIND_NEAR_PI = 2'd2;

   localparam logic CSR_ZERO_THRESHOLD = 1'b0;
   localparam logic CSR_NEAR_PI_THRESHOLD = 1'b1;

   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0: atan_q30 = 30'd843314857;
         5'd1: atan_q30 = 30'd497837830;
         5'd2: atan_q30 = 30'd263043837;
         5'd3: atan_q30 = 30'd133525159;
         5'd4: atan_q30 = 30'd67021687;
         5'd5: atan_q30 = 30'd33543516;
         5'd6: atan_q30 = 30'd16775851;
         5'd7: atan_q30 = 30'd8388437;
         5'd8: atan_q30 = 30'd4194283;
         5'd9: atan_q30 = 30'd2097149;
         5'd10: atan_q30 = 30'd1048576;
         5'd11: atan_q30 = 30'd524288;
         5'd12: atan_q30 = 30'd262144;
         5'd13: atan_q30 = 30'd131072;
         5'd14: atan_q30 = 30'd65536;
         5'd15: atan_q30 = 30'd32768;
         5'd16: atan_q30 = 30'd16384;
         5'd17: atan_q30 = 30'd8192;
         5'd18: atan_q30 = 30'd4096;
         5'd19: atan_q30 = 30'd2048;
         5'd20: atan_q30 = 30'd1024;
         5'd21: atan_q30 = 30'd512;
         5'd22: atan_q30 = 30'd256;
         5'd23: atan_q30 = 30'd128;
         default: atan_q30 = 30'd0;
      endcase
   endfunction

   typedef struct packed {
      logic start;
      logic [1:0] op;
   } unit_cmd_type;

   localparam logic [1:0] OP_SQRT = 2'd0;
   localparam logic [1:0] OP_DIV = 2'd1;
endpackage

/* hw/rtl/rmaa_sqrtdiv.sv */
`timescale 1ns / 1ps
// shared restoring square root (one result bit per cycle) and divider
module rmaa_sqrtdiv (
   input  logic                  clock,
   input  logic                  reset,
   input  rmaa_pkg::unit_cmd_type cmd,
   input  logic [63:0]           a,
   input  logic [31:0]           b,
   output logic                  done,
   output logic [63:0]           result
);
   logic [63:0] rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [63:0] num_ff, num_in;
   logic [6:0] cnt_ff, cnt_in;
   logic op_ff, op_in, run_ff, run_in, done_ff, done_in;
   logic [64:0] trial;

   assign done = done_ff;
   assign result = res_ff;

   always_comb begin
      rem_in = rem_ff; res_in = res_ff; bit_in = bit_ff; num_in = num_ff;
      cnt_in = cnt_ff; op_in = op_ff; run_in = run_ff; done_in = 1'b0;
      trial = '0;
      if (cmd.start) begin
         run_in = 1'b1;
         op_in = (cmd.op == rmaa_pkg::OP_DIV);
         res_in = '0;
         if (cmd.op == rmaa_pkg::OP_DIV) begin
            rem_in = '0; num_in = a; cnt_in = 7'd64;
         end else begin
            rem_in = a; bit_in = 64'd1 << 62; cnt_in = 7'd32;
         end
      end else if (run_ff) begin
         if (op_ff) begin
            trial = {rem_ff, num_ff[63]} - {33'd0, b};
            num_in = {num_ff[62:0], 1'b0};
            if (!trial[64]) begin
               rem_in = trial[63:0]; res_in = {res_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], num_ff[63]}; res_in = {res_ff[62:0], 1'b0};
            end
         end else begin
            trial = {1'b0, rem_ff} - {1'b0, res_ff + bit_ff};
            if (!trial[64]) begin
               rem_in = trial[63:0]; res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0; op_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; cnt_ff <= cnt_in; op_ff <= op_in;
      end
      rem_ff <= rem_in; res_ff <= res_in; bit_ff <= bit_in; num_ff <= num_in;
   end
endmodule

/* hw/rtl/rotation_matrix_to_axis_angle.sv */
`timescale 1ns / 1ps
// Rotation matrix to axis-angle converter.
// Input: req_m00..req_m22 (Q2.14), accepted when start is high and busy low.
// busy stays high while one item is in work; it falls together with rsp_valid
// and the next item can be accepted at the following edge.
// Output: rsp_angle (Q2.13), rsp_axis_x/y/z (Q1.14), rsp_case_kind, shown
// for one cycle with rsp_valid. The receiver cannot stall; nothing waits.
// Steps in order: square root, CORDIC_ITERATIONS CORDIC steps (no more than
// ATAN_ENTRIES), case selection (S_SEL, S_WAIT), a length root, three divisions
// and the output state. A zero angle skips the length root and the divisions,
// a zero-length axis skips the divisions. A new item is taken only once the result
// is shown; all roots and divisions run on the shared bit-serial root/divide unit.
// Configuration: csr_valid/csr_ready, csr_index 0 zero_threshold,
// 1 near_pi_threshold; write only while idle. csr_ready is always high.
// Reset (synchronous, active high) returns thresholds to 0 and 16 and
// drops any item in work.
module rotation_matrix_to_axis_angle #(
   parameter int CORDIC_ITERATIONS = rmaa_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_m00, req_m01, req_m02,
   input  logic signed [15:0] req_m10, req_m11, req_m12,
   input  logic signed [15:0] req_m20, req_m21, req_m22,
   output logic               rsp_valid,
   output logic [14:0]        rsp_angle,
   output logic signed [15:0] rsp_axis_x, rsp_axis_y, rsp_axis_z,
   output logic [1:0]         rsp_case_kind,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [12:0]        csr_data
);
   localparam int FRACTION_BITS = rmaa_pkg::FRACTION_BITS_DEF;
   localparam int ONE = 1 << FRACTION_BITS;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_SQ = 8'b00000010, S_CORD = 8'b00000100,
      S_SEL = 8'b00001000, S_LEN = 8'b00010000, S_DIV = 8'b00100000,
      S_OUT = 8'b01000000, S_WAIT = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [10:0] zt_ff;
   logic [12:0] npt_ff;
   logic signed [15:0] m_ff [9];
   logic signed [19:0] c2_ff;
   logic [31:0] s2_ff;
   logic signed [39:0] x_ff, y_ff, x_in, y_in;
   logic signed [35:0] z_ff, z_in;
   logic [4:0] it_ff, it_in;
   logic signed [19:0] v_ff [3];
   logic [31:0] len_ff;
   logic [1:0] idx_ff, idx_in;
   logic signed [15:0] ax_ff [3];
   logic [14:0] ang_ff;
   logic [1:0] kind_ff;
   logic ustart_ff;
   rmaa_pkg::unit_cmd_type cmd;
   logic [63:0] ua, ures;
   logic udone;

   assign csr_ready = 1'b1;
   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         zt_ff <= '0; npt_ff <= 13'd16;
      end else if (csr_valid) begin
         if (csr_index == rmaa_pkg::CSR_ZERO_THRESHOLD) zt_ff <= csr_data[10:0];
         else npt_ff <= csr_data;
      end
   end

   logic signed [19:0] trace, c2c;
   logic signed [39:0] c2sq;
   logic [63:0] sq_n;
   always_comb begin
      trace = 20'(req_m00) + 20'(req_m11) + 20'(req_m22);
      c2c = trace - 20'(ONE);
      if (c2c > 20'(2 * ONE)) c2c = 20'(2 * ONE);
      if (c2c < -20'(2 * ONE)) c2c = -20'(2 * ONE);
      c2sq = c2c * c2c;
      sq_n = 64'(4 * ONE * ONE) - 64'(c2sq);
   end

   // near-pi and general axis candidates, clamped angle and squared axis length
   logic signed [19:0] tr_r, dvec [3], u [3], un [3];
   logic signed [43:0] dot;
   logic [1:0] kk;
   logic [32:0] zc;
   logic [14:0] angc;
   logic signed [41:0] sqsum;
   always_comb begin
      tr_r = 20'(m_ff[0]) + 20'(m_ff[4]) + 20'(m_ff[8]);
      dvec[0] = 20'(m_ff[7]) - 20'(m_ff[5]);
      dvec[1] = 20'(m_ff[2]) - 20'(m_ff[6]);
      dvec[2] = 20'(m_ff[3]) - 20'(m_ff[1]);
      kk = 2'd0;
      if (m_ff[4] > m_ff[0]) kk = 2'd1;
      if (m_ff[8] > m_ff[kk == 2'd1 ? 4 : 0]) kk = 2'd2;
      case (kk)
         2'd0: begin
            u[0] = 20'(ONE) + 20'(2 * m_ff[0]) - tr_r;
            u[1] = 20'(m_ff[1]) + 20'(m_ff[3]); u[2] = 20'(m_ff[2]) + 20'(m_ff[6]);
         end
         2'd1: begin
            u[1] = 20'(ONE) + 20'(2 * m_ff[4]) - tr_r;
            u[0] = 20'(m_ff[3]) + 20'(m_ff[1]); u[2] = 20'(m_ff[5]) + 20'(m_ff[7]);
         end
         default: begin
            u[2] = 20'(ONE) + 20'(2 * m_ff[8]) - tr_r;
            u[0] = 20'(m_ff[6]) + 20'(m_ff[2]); u[1] = 20'(m_ff[7]) + 20'(m_ff[5]);
         end
      endcase
      dot = 44'(u[0]) * 44'(dvec[0]) + 44'(u[1]) * 44'(dvec[1])
          + 44'(u[2]) * 44'(dvec[2]);
      for (int i = 0; i < 3; i++) un[i] = dot[43] ? -u[i] : u[i];
      if (z_ff < 0) zc = '0;
      else if (z_ff > 36'(rmaa_pkg::PI_Q30)) zc = 33'(rmaa_pkg::PI_Q30);
      else zc = z_ff[32:0];
      angc = 15'((34'(zc) + (34'd1 << (30 - FRACTION_BITS))) >> (31 - FRACTION_BITS));
      sqsum = 42'(v_ff[0]) * 42'(v_ff[0]) + 42'(v_ff[1]) * 42'(v_ff[1])
            + 42'(v_ff[2]) * 42'(v_ff[2]);
   end

   logic signed [19:0] vmag;
   logic [63:0] q;
   always_comb begin
      state_in = state_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff; it_in = it_ff;
      idx_in = idx_ff; cmd = '0; ua = '0;
      vmag = v_ff[idx_ff] < 0 ? -v_ff[idx_ff] : v_ff[idx_ff];
      q = ures > 64'(ONE) ? 64'(ONE) : ures;
      case (state_ff)
         S_IDLE: if (start) begin
            state_in = S_SQ; cmd.start = 1'b1; cmd.op = rmaa_pkg::OP_SQRT; ua = sq_n;
         end
         S_SQ: if (udone) begin
            state_in = S_CORD; it_in = '0;
            if (c2_ff < 0) begin
               x_in = 40'(ures[31:0]) <<< 8; y_in = -(40'(c2_ff) <<< 8);
               z_in = 36'(rmaa_pkg::HALF_PI_Q30);
            end else begin
               x_in = 40'(c2_ff) <<< 8; y_in = 40'(ures[31:0]) <<< 8; z_in = '0;
            end
         end
         S_CORD: begin
            if (y_ff > 0) begin
               x_in = x_ff + (y_ff >>> it_ff); y_in = y_ff - (x_ff >>> it_ff);
               z_in = z_ff + 36'(rmaa_pkg::atan_q30(it_ff));
            end else begin
               x_in = x_ff - (y_ff >>> it_ff); y_in = y_ff + (x_ff >>> it_ff);
               z_in = z_ff - 36'(rmaa_pkg::atan_q30(it_ff));
            end
            it_in = it_ff + 5'd1;
            if (32'(it_ff) == CORDIC_ITERATIONS - 1 || it_ff == 5'(rmaa_pkg::ATAN_ENTRIES - 1))
               state_in = S_SEL;
         end
         S_SEL: state_in = S_WAIT;
         S_WAIT: begin
            idx_in = '0;
            if (kind_ff == rmaa_pkg::KIND_ZERO) state_in = S_OUT;
            else begin
               state_in = S_LEN; cmd.start = 1'b1; cmd.op = rmaa_pkg::OP_SQRT;
               ua = 64'(sqsum) << 24;
            end
         end
         S_LEN: if (udone) begin
            if (ures == 0) state_in = S_OUT;
            else begin
               state_in = S_DIV; idx_in = '0; cmd.start = 1'b1; cmd.op = rmaa_pkg::OP_DIV;
               ua = (64'(vmag) << (FRACTION_BITS + 12)) + 64'(ures[31:1]);
            end
         end
         S_DIV: if (udone) begin
            if (idx_ff == 2'd2) state_in = S_OUT;
            else begin
               idx_in = idx_ff + 2'd1; cmd.start = 1'b1; cmd.op = rmaa_pkg::OP_DIV;
               ua = (64'(v_ff[idx_ff + 2'd1] < 0 ? -v_ff[idx_ff + 2'd1] : v_ff[idx_ff + 2'd1])
                     << (FRACTION_BITS + 12)) + 64'(len_ff[31:1]);
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   rmaa_sqrtdiv u_unit (.clock(clock), .reset(reset), .cmd(cmd), .a(ua),
      .b(state_ff == S_LEN ? ures[31:0] : len_ff), .done(udone), .result(ures));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in; rsp_valid <= (state_ff == S_OUT);
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; it_ff <= it_in; idx_ff <= idx_in;
      ustart_ff <= cmd.start;
      if (state_ff == S_IDLE && start) begin
         m_ff[0] <= req_m00; m_ff[1] <= req_m01; m_ff[2] <= req_m02;
         m_ff[3] <= req_m10; m_ff[4] <= req_m11; m_ff[5] <= req_m12;
         m_ff[6] <= req_m20; m_ff[7] <= req_m21; m_ff[8] <= req_m22;
         c2_ff <= c2c;
      end
      if (state_ff == S_SQ && udone) s2_ff <= ures[31:0];
      if (state_ff == S_SEL) begin
         ang_ff <= angc;
         ax_ff[0] <= '0; ax_ff[1] <= '0; ax_ff[2] <= 16'(ONE);
         if (angc <= 15'(zt_ff)) kind_ff <= rmaa_pkg::KIND_ZERO;
         else if ({1'b0, s2_ff[31:1]} <= 32'(npt_ff) && c2_ff < 0) begin
            kind_ff <= rmaa_pkg::KIND_NEAR_PI;
            v_ff[0] <= un[0]; v_ff[1] <= un[1]; v_ff[2] <= un[2];
         end else begin
            kind_ff <= rmaa_pkg::KIND_GENERAL;
            v_ff[0] <= dvec[0]; v_ff[1] <= dvec[1]; v_ff[2] <= dvec[2];
         end
      end
      if (state_ff == S_LEN && udone) len_ff <= ures[31:0];
      if (state_ff == S_DIV && udone)
         ax_ff[idx_ff] <= v_ff[idx_ff] < 0 ? -16'(q) : 16'(q);
      if (state_ff == S_OUT) begin
         rsp_angle <= ang_ff; rsp_axis_x <= ax_ff[0]; rsp_axis_y <= ax_ff[1];
         rsp_axis_z <= ax_ff[2]; rsp_case_kind <= kind_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_unit_idle: assert property (@(posedge clock) disable iff (reset)
      ustart_ff |-> !udone) else $error("unit restart overlap");
`endif
endmodule
